@@ design/bae_pkg.sv @@
// Shared types and constants of the binary arithmetic encoder.
package bae_pkg;

  localparam logic CMD_ENCODE = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  localparam logic REG_ZERO_COUNT = 1'b0;
  localparam logic REG_ONE_COUNT  = 1'b1;

  localparam int unsigned BoundW = 32;

  localparam logic [BoundW-1:0] HIGH_RESET = 32'h7FFF_FFFF;
  localparam logic [BoundW-1:0] LOW_KEEP   = 32'h3FFF_FFFF;
  localparam logic [BoundW-1:0] SMSB       = 32'h4000_0000;
  localparam logic [4:0]        TAIL_LAST  = 5'd30;
  localparam logic [5:0]        DIV_STEPS  = 6'd33;

  // Request to the multiply and divide unit.
  typedef struct packed {
    logic        start;
    logic [32:0] range;
    logic [29:0] zero_w;
    logic [30:0] sum;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quot;
  } div_rsp_t;

endpackage

@@ design/bae_div.sv @@
// Split point unit of the encoder: one multiply, then a bit-serial restoring divide.
module bae_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bae_pkg::div_req_t req_i,
  output bae_pkg::div_rsp_t rsp_o
);
  import bae_pkg::*;

  logic [62:0] prod;
  logic [30:0] rem_q, rem_d;
  logic [32:0] dvd_q, dvd_d;
  logic [30:0] sum_q;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [31:0] trial;
  logic        ge;

  assign prod  = 63'(req_i.range) * 63'(req_i.zero_w);
  assign trial = {rem_q, dvd_q[32]};
  assign ge    = trial >= {1'b0, sum_q};

  always_comb begin
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      if (req_i.sum == '0) begin
        // With no weights at all the interval is simply halved.
        dvd_d  = {1'b0, req_i.range[32:1]};
        done_d = 1'b1;
      end else begin
        rem_d  = {1'b0, prod[62:33]};
        dvd_d  = prod[32:0];
        cnt_d  = DIV_STEPS;
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      rem_d = ge ? 31'(trial - {1'b0, sum_q}) : trial[30:0];
      dvd_d = {dvd_q[31:0], ge};
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    if (req_i.start) begin
      sum_q <= req_i.sum;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = dvd_q[31:0];

endmodule

@@ design/binary_arithmetic_encoder.sv @@
// Binary arithmetic encoder with a static two-symbol model and run-length output.
// Timing: an encode request passes a start state, one multiply and a 33-step divide in the
// split point unit (no divide when both weights are zero), then emits each settled MSB and
// its pending bits, shifts once per underflow and closes; a finish request needs no divide.
// Throughput: one request at a time, the next accepted in the cycle after the last closes,
// which stalls delay. Reset sets bounds, pending count, bit phase and both weights at once.
module binary_arithmetic_encoder #(
  parameter int unsigned PENDING_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration writes.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [29:0] cfg_data_i,
  // Input requests.
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        cmd_i,
  input  logic        symbol_bit_i,
  // Output runs.
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        bit_value_o,
  output logic [31:0] repeat_count_o,
  output logic        item_done_o,
  output logic        stream_done_o
);
  import bae_pkg::*;

  // The pending counter never needs more than 32 bits, since a run cannot be longer.
  localparam int unsigned PendW = (PENDING_BITS < 32) ? PENDING_BITS : 32;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_START = 4'd1;
  localparam logic [3:0] S_DIV   = 4'd2;
  localparam logic [3:0] S_CHECK = 4'd3;
  localparam logic [3:0] S_PEND  = 4'd4;
  localparam logic [3:0] S_FMSB  = 4'd5;
  localparam logic [3:0] S_FPEND = 4'd6;
  localparam logic [3:0] S_FBITS = 4'd7;
  localparam logic [3:0] S_FPAD  = 4'd8;
  localparam logic [3:0] S_END   = 4'd9;

  logic [3:0]       state_q, state_d;
  logic [29:0]      zero_q, one_q;
  logic [31:0]      low_q, low_d, high_q, high_d;
  logic [PendW-1:0] pend_q, pend_d;
  logic [2:0]       phase_q, phase_d;
  logic             sym_q, fin_q, fin_d, sym_d;
  logic [32:0]      range_q, range_d;
  logic [4:0]       tail_q, tail_d;

  // The run being built; it is handed to the output register once it can grow no more.
  logic             run_valid_q, run_valid_d;
  logic             run_v_q, run_v_d;
  logic [31:0]      run_cnt_q, run_cnt_d;

  logic             out_valid_q, out_valid_d;
  logic             out_bit_q, out_bit_d;
  logic [31:0]      out_cnt_q, out_cnt_d;
  logic             out_item_q, out_item_d;
  logic             out_stream_q, out_stream_d;
  logic             out_free;

  // Bit emission request from the sequencer and whether it went through this cycle.
  logic             put_req, put_v, put_merge, put_done;
  logic [31:0]      put_n;
  logic [32:0]      run_sum;

  div_req_t         div_req;
  div_rsp_t         div_rsp;

  bae_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign run_sum     = {1'b0, run_cnt_q} + {1'b0, put_n};

  assign div_req.start  = (state_q == S_START);
  assign div_req.range  = range_q;
  assign div_req.zero_w = zero_q;
  assign div_req.sum    = {1'b0, zero_q} + {1'b0, one_q};

  // Sequencer: chooses what to emit this cycle and how the bounds move.
  always_comb begin
    state_d   = state_q;
    low_d     = low_q;
    high_d    = high_q;
    pend_d    = pend_q;
    fin_d     = fin_q;
    sym_d     = sym_q;
    range_d   = range_q;
    tail_d    = tail_q;
    put_req   = 1'b0;
    put_v     = 1'b0;
    put_n     = 32'd1;
    put_merge = 1'b1;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          fin_d   = (cmd_i == CMD_FINISH);
          sym_d   = symbol_bit_i;
          range_d = {1'b0, high_q - low_q} + 33'd1;
          state_d = (cmd_i == CMD_FINISH) ? S_FMSB : S_START;
        end
      end
      S_START: begin
        state_d = S_DIV;
      end
      S_DIV: begin
        if (div_rsp.done) begin
          if (sym_q) begin
            low_d = low_q + div_rsp.quot;
          end else begin
            high_d = low_q + div_rsp.quot - 32'd1;
          end
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (low_q[31] == high_q[31]) begin
          // Matching top bits: the bit is settled and goes out.
          put_req = 1'b1;
          put_v   = high_q[31];
          if (put_done) begin
            state_d = S_PEND;
          end
        end else if (low_q[30] && !high_q[30]) begin
          // Underflow: drop the second bit and remember one more opposite bit.
          if (pend_q != '1) begin
            pend_d = pend_q + PendW'(1);
          end
          low_d  = (low_q & LOW_KEEP) << 1;
          high_d = ((high_q | SMSB) << 1) | 32'd1;
        end else begin
          state_d = S_END;
        end
      end
      S_PEND: begin
        put_req = 1'b1;
        put_v   = ~high_q[31];
        put_n   = 32'(pend_q);
        if (put_done) begin
          pend_d  = '0;
          low_d   = low_q << 1;
          high_d  = (high_q << 1) | 32'd1;
          state_d = S_CHECK;
        end
      end
      S_FMSB: begin
        put_req = 1'b1;
        put_v   = low_q[31];
        if (put_done) begin
          state_d = S_FPEND;
        end
      end
      S_FPEND: begin
        put_req = 1'b1;
        put_v   = 1'b1;
        put_n   = 32'(pend_q);
        if (put_done) begin
          tail_d  = TAIL_LAST;
          state_d = S_FBITS;
        end
      end
      S_FBITS: begin
        put_req = 1'b1;
        put_v   = low_q[30];
        if (put_done) begin
          low_d  = low_q << 1;
          tail_d = tail_q - 5'd1;
          if (tail_q == '0) begin
            state_d = S_FPAD;
          end
        end
      end
      S_FPAD: begin
        // Padding to a byte boundary always starts a run of its own.
        put_req   = 1'b1;
        put_v     = 1'b0;
        put_n     = 32'(4'd8 - {1'b0, phase_q});
        put_merge = 1'b0;
        if (put_done) begin
          state_d = S_END;
        end
      end
      S_END: begin
        if (!run_valid_q || out_free) begin
          state_d = S_IDLE;
          if (fin_q) begin
            low_d  = '0;
            high_d = HIGH_RESET;
            pend_d = '0;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Run builder and output register. New bits either extend the open run or close it;
  // closing needs the output register to be free, otherwise the sequencer waits.
  always_comb begin
    put_done     = 1'b0;
    run_valid_d  = run_valid_q;
    run_v_d      = run_v_q;
    run_cnt_d    = run_cnt_q;
    phase_d      = phase_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_bit_d    = out_bit_q;
    out_cnt_d    = out_cnt_q;
    out_item_d   = out_item_q;
    out_stream_d = out_stream_q;

    if (put_req) begin
      if (put_n == '0) begin
        put_done = 1'b1;
      end else if (run_valid_q && put_merge && (run_v_q == put_v) && !run_sum[32]) begin
        put_done  = 1'b1;
        run_cnt_d = run_sum[31:0];
      end else if (!run_valid_q || out_free) begin
        put_done = 1'b1;
        if (run_valid_q) begin
          out_valid_d  = 1'b1;
          out_bit_d    = run_v_q;
          out_cnt_d    = run_cnt_q;
          out_item_d   = 1'b0;
          out_stream_d = 1'b0;
        end
        run_valid_d = 1'b1;
        run_v_d     = put_v;
        run_cnt_d   = put_n;
      end
      if (put_done) begin
        phase_d = phase_q + put_n[2:0];
      end
    end

    if (state_q == S_END && run_valid_q && out_free) begin
      out_valid_d  = 1'b1;
      out_bit_d    = run_v_q;
      out_cnt_d    = run_cnt_q;
      out_item_d   = 1'b1;
      out_stream_d = fin_q;
      run_valid_d  = 1'b0;
    end
    if (state_q == S_END && fin_q) begin
      phase_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      zero_q      <= 30'd1;
      one_q       <= 30'd1;
      low_q       <= '0;
      high_q      <= HIGH_RESET;
      pend_q      <= '0;
      phase_q     <= '0;
      run_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      low_q       <= low_d;
      high_q      <= high_d;
      pend_q      <= pend_d;
      phase_q     <= phase_d;
      run_valid_q <= run_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == REG_ZERO_COUNT) begin
          zero_q <= cfg_data_i;
        end else begin
          one_q <= cfg_data_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    fin_q        <= fin_d;
    sym_q        <= sym_d;
    range_q      <= range_d;
    tail_q       <= tail_d;
    run_v_q      <= run_v_d;
    run_cnt_q    <= run_cnt_d;
    out_bit_q    <= out_bit_d;
    out_cnt_q    <= out_cnt_d;
    out_item_q   <= out_item_d;
    out_stream_q <= out_stream_d;
  end

  assign out_valid_o    = out_valid_q;
  assign bit_value_o    = out_bit_q;
  assign repeat_count_o = out_cnt_q;
  assign item_done_o    = out_item_q;
  assign stream_done_o  = out_stream_q;

endmodule

@@ dv/bae_checker.sv @@
// Checker that predicts and compares the output runs of the binary arithmetic encoder.
`timescale 1ns / 1ps
module bae_checker #(
  parameter int unsigned PENDING_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic        cfg_index_i,
  input  logic [29:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic        cmd_i,
  input  logic        symbol_bit_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic        bit_value_i,
  input  logic [31:0] repeat_count_i,
  input  logic        item_done_i,
  input  logic        stream_done_i,
  output int unsigned mismatch_count_o,
  output int unsigned runs_awaited_o
);
  import bae_pkg::*;

  localparam logic [63:0] RUN_LIMIT    = 64'h0000_0000_FFFF_FFFF;
  localparam int unsigned MAX_RUNS     = 34;
  localparam logic [63:0] PENDING_CEIL =
    (PENDING_BITS >= 32) ? RUN_LIMIT : ((64'd1 << PENDING_BITS) - 64'd1);

  typedef struct packed {
    logic        bit_value;
    logic [31:0] repeat_count;
    logic        item_done;
    logic        stream_done;
  } run_t;

  run_t        expected_runs[$];
  run_t        request_runs[$];
  logic [29:0] zero_w;
  logic [29:0] one_w;
  logic [31:0] low_q;
  logic [31:0] high_q;
  logic [63:0] pending_q;
  logic [2:0]  phase_q;
  int unsigned mismatches;

  function automatic void clear_coder();
    low_q     = '0;
    high_q    = HIGH_RESET;
    pending_q = '0;
    phase_q   = '0;
  endfunction

  // Appends n bits of one value, joining them to the previous run of this request where allowed.
  function automatic void emit_bits(input logic value, input logic [63:0] n,
                                    input logic mergeable);
    run_t        last;
    run_t        fresh;
    logic [63:0] joined;
    if (n == 0) return;
    phase_q = phase_q + n[2:0];
    if (mergeable && request_runs.size() > 0) begin
      last   = request_runs[request_runs.size() - 1];
      joined = {32'd0, last.repeat_count} + n;
      if (last.bit_value == value && joined <= RUN_LIMIT) begin
        last.repeat_count = joined[31:0];
        request_runs[request_runs.size() - 1] = last;
        return;
      end
    end
    if (request_runs.size() >= MAX_RUNS) return;
    fresh.bit_value    = value;
    fresh.repeat_count = n[31:0];
    fresh.item_done    = 1'b0;
    fresh.stream_done  = 1'b0;
    request_runs.insert(request_runs.size(), fresh);
  endfunction

  function automatic void encode_symbol(input logic symbol);
    logic [63:0] span;
    logic [63:0] weight_sum;
    logic [31:0] split;
    int          shift;
    span       = {32'd0, high_q - low_q} + 64'd1;
    weight_sum = {34'd0, zero_w} + {34'd0, one_w};
    if (weight_sum != 0) split = 32'((span * {34'd0, zero_w}) / weight_sum);
    else split = span[32:1];
    if (symbol == 1'b0) high_q = low_q + split - 32'd1;
    else low_q = low_q + split;
    for (shift = 0; shift < 64; shift++) begin
      if (high_q[31] == low_q[31]) begin
        emit_bits(high_q[31], 64'd1, 1'b1);
        emit_bits(~high_q[31], pending_q, 1'b1);
        pending_q = '0;
      end else if (low_q[30] && !high_q[30]) begin
        // Underflow: the interval straddles the midpoint, so defer the bit.
        if (pending_q < PENDING_CEIL) pending_q = pending_q + 64'd1;
        low_q  = low_q & LOW_KEEP;
        high_q = high_q | SMSB;
      end else begin
        break;
      end
      low_q  = low_q << 1;
      high_q = {high_q[30:0], 1'b1};
    end
  endfunction

  function automatic void finish_stream();
    logic [31:0] tail;
    run_t        last;
    int          i;
    tail = low_q;
    emit_bits(tail[31], 64'd1, 1'b1);
    emit_bits(1'b1, pending_q, 1'b1);
    for (i = 0; i < 31; i++) begin
      tail = tail << 1;
      emit_bits(tail[31], 64'd1, 1'b1);
    end
    // The padding run always stands on its own.
    emit_bits(1'b0, 64'd8 - {61'd0, phase_q}, 1'b0);
    last = request_runs[request_runs.size() - 1];
    last.stream_done = 1'b1;
    request_runs[request_runs.size() - 1] = last;
    clear_coder();
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    run_t got;
    run_t want;
    run_t last;
    if (!rst_ni) begin
      zero_w = 30'd1;
      one_w  = 30'd1;
      clear_coder();
      expected_runs.delete();
      mismatches = 0;
      mismatch_count_o <= 0;
      runs_awaited_o   <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got = '{bit_value_i, repeat_count_i, item_done_i, stream_done_i};
        if (expected_runs.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: run with nothing expected: value %0b count %0d item %0b stream %0b",
                     $time, got.bit_value, got.repeat_count, got.item_done, got.stream_done);
        end else begin
          want = expected_runs.pop_front();
          if (got != want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: run mismatch: expected %0b/%0d/%0b/%0b, got %0b/%0d/%0b/%0b",
                       $time, want.bit_value, want.repeat_count, want.item_done,
                       want.stream_done, got.bit_value, got.repeat_count, got.item_done,
                       got.stream_done);
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == REG_ZERO_COUNT) zero_w = cfg_data_i;
        else one_w = cfg_data_i;
      end
      if (in_valid_i && !in_stall_i) begin
        request_runs.delete();
        if (cmd_i == CMD_FINISH) finish_stream();
        else encode_symbol(symbol_bit_i);
        if (request_runs.size() > 0) begin
          last = request_runs[request_runs.size() - 1];
          last.item_done = 1'b1;
          request_runs[request_runs.size() - 1] = last;
        end
        foreach (request_runs[k]) expected_runs.insert(expected_runs.size(), request_runs[k]);
      end
      mismatch_count_o <= mismatches;
      runs_awaited_o   <= expected_runs.size();
    end
  end

endmodule

@@ dv/binary_arithmetic_encoder_tb.sv @@
// Top of the binary arithmetic encoder testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module binary_arithmetic_encoder_tb;
  import bae_pkg::*;

  localparam int unsigned PendingBits = 32;
  // Cycles with no accepted request or run before the run is declared hung. The slowest
  // legitimate gap is a long request whose runs are all stalled.
  localparam int unsigned QuietLimit  = 20000;
  // Extra hold-off once the encoder is idle, before a weight write or the verdict.
  localparam int unsigned SettleCycles = 64;
  localparam logic [29:0] WeightMax = 30'h3FFF_FFFF;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        cfg_valid_i  = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i  = REG_ZERO_COUNT;
  logic [29:0] cfg_data_i   = '0;
  logic        in_valid_i   = 1'b0;
  logic        in_stall_o;
  logic        cmd_i        = CMD_ENCODE;
  logic        symbol_bit_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i  = 1'b0;
  logic        bit_value_o;
  logic [31:0] repeat_count_o;
  logic        item_done_o;
  logic        stream_done_o;

  int unsigned mismatch_count;
  int unsigned runs_awaited;
  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;
  int unsigned quiet_cycles = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  binary_arithmetic_encoder #(
    .PENDING_BITS(PendingBits)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .cmd_i         (cmd_i),
    .symbol_bit_i  (symbol_bit_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .bit_value_o   (bit_value_o),
    .repeat_count_o(repeat_count_o),
    .item_done_o   (item_done_o),
    .stream_done_o (stream_done_o)
  );

  bae_checker #(
    .PENDING_BITS(PendingBits)
  ) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_i     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .cmd_i           (cmd_i),
    .symbol_bit_i    (symbol_bit_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .bit_value_i     (bit_value_o),
    .repeat_count_i  (repeat_count_o),
    .item_done_i     (item_done_o),
    .stream_done_i   (stream_done_o),
    .mismatch_count_o(mismatch_count),
    .runs_awaited_o  (runs_awaited)
  );

  // The receiver stalls at random; the percentage is set per phase by the main sequence.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // Watchdog: any accepted request, run or register write restarts the count.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QuietLimit) begin
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Offers one request, after a random idle spell, and returns at the edge that accepts it.
  // Valid is left high so that a following request can go out back to back.
  task automatic send_request(input logic cmd, input logic symbol);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    cmd_i        <= cmd;
    symbol_bit_i <= symbol;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Stops offering requests until every predicted run has been received and the encoder
  // has gone idle, so that a request emitting no run at all is also complete.
  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (runs_awaited != 0 || in_stall_o);
  endtask

  // Writes both weights back to back; only called while the encoder is idle.
  task automatic set_weights(input logic [29:0] zero_weight, input logic [29:0] one_weight);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= REG_ZERO_COUNT;
    cfg_data_i  <= zero_weight;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_index_i <= REG_ONE_COUNT;
    cfg_data_i  <= one_weight;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // Random streams: runs of encode requests whose symbols lean towards one value by a
  // random bias, each closed by a finish request. A stream of length zero gives two
  // finish requests in a row. Halfway through, the sender waits for the output to drain.
  task automatic encode_streams(input int unsigned count);
    int unsigned stream_left;
    int unsigned bias;
    int unsigned k;
    stream_left = $urandom_range(24, 1);
    bias        = $urandom_range(100);
    for (k = 0; k < count; k++) begin
      if (k == count / 2) wait_for_drain();
      if (stream_left == 0) begin
        send_request(CMD_FINISH, 1'($urandom_range(1)));
        stream_left = ($urandom_range(9) == 0) ? 0 : $urandom_range(30, 1);
        bias        = $urandom_range(100);
      end else begin
        send_request(CMD_ENCODE, ($urandom_range(99) < bias));
        stream_left--;
      end
    end
  endtask

  initial begin
    int unsigned phase;
    logic [29:0] zero_weight;
    logic [29:0] one_weight;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed requests at the reset weights, with neither side idling. Both symbols,
    // a finish after a few symbols, two finish requests in a row (the second flushes an
    // untouched interval and pads a whole byte), and a finish carrying either symbol bit.
    send_request(CMD_ENCODE, 1'b0);
    send_request(CMD_ENCODE, 1'b1);
    send_request(CMD_ENCODE, 1'b1);
    send_request(CMD_ENCODE, 1'b0);
    send_request(CMD_FINISH, 1'b0);
    send_request(CMD_FINISH, 1'b1);
    repeat (4) send_request(CMD_ENCODE, 1'b1);
    repeat (4) send_request(CMD_ENCODE, 1'b0);
    send_request(CMD_FINISH, 1'b1);
    encode_streams(10);

    // Each later phase writes a new pair of weights, extremes first, and changes how
    // the two sides idle, in turn: sender mostly idle, receiver mostly stalling, both, then none.
    for (phase = 1; phase < 8; phase++) begin
      wait_for_drain();
      repeat (SettleCycles) @(posedge clk_i);
      case (phase % 4)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 84;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 84;
        end
        default: begin
          idle_pct  = 26;
          stall_pct = 26;
        end
      endcase
      case (phase)
        // A zero weight sum makes the split fall at half the range.
        1: begin
          zero_weight = '0;
          one_weight  = '0;
        end
        2: begin
          zero_weight = WeightMax;
          one_weight  = WeightMax;
        end
        // One weight zero: the interval of that symbol is empty and the bounds wrap.
        3: begin
          zero_weight = '0;
          one_weight  = WeightMax;
        end
        4: begin
          zero_weight = WeightMax;
          one_weight  = '0;
        end
        5: begin
          zero_weight = 30'd1;
          one_weight  = WeightMax;
        end
        6: begin
          zero_weight = 30'($urandom());
          one_weight  = 30'($urandom());
        end
        default: begin
          zero_weight = 30'($urandom_range(15, 1));
          one_weight  = 30'($urandom_range(15, 1));
        end
      endcase
      set_weights(zero_weight, one_weight);
      encode_streams(28);
    end

    wait_for_drain();
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
